@@ src/marker_table_range_bearing_defines.svh @@
// ----------------------------------------------------------------------------
// Marker table assertion macros
// Shared property wrappers, clocked on i_clk with reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef MARKER_TABLE_RANGE_BEARING_DEFINES_SVH
`define MARKER_TABLE_RANGE_BEARING_DEFINES_SVH

// check a consequence in the same cycle
`define MTRB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence in the following cycle
`define MTRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mtrb_pkg.sv @@
// ----------------------------------------------------------------------------
// Marker table package
// Sizes, angle constants, the arctangent step table and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mtrb_pkg;

    localparam int CAPACITY     = 32;
    localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int ANG_W        = 24;
    localparam int CIN_W        = 36;
    localparam int CW           = 38;
    localparam int CORDIC_STEPS = 16;
    localparam int MM_SCALE     = 1000;

    localparam logic signed [ANG_W-1:0] ANG_PI     = 24'sd205887;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 24'sd411774;

    // arctangent of 2^-i in units of 2^-16 rad
    function automatic logic signed [ANG_W-1:0] atan_step(input logic [3:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            4'd0:    v = 24'sd51472;
            4'd1:    v = 24'sd30386;
            4'd2:    v = 24'sd16055;
            4'd3:    v = 24'sd8150;
            4'd4:    v = 24'sd4091;
            4'd5:    v = 24'sd2047;
            4'd6:    v = 24'sd1024;
            4'd7:    v = 24'sd512;
            4'd8:    v = 24'sd256;
            4'd9:    v = 24'sd128;
            4'd10:   v = 24'sd64;
            4'd11:   v = 24'sd32;
            4'd12:   v = 24'sd16;
            4'd13:   v = 24'sd8;
            4'd14:   v = 24'sd4;
            default: v = 24'sd2;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic              is_pose;
        logic              hold_pos;
        logic [9:0]        id;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_item;

    typedef struct packed {
        logic [9:0]        id;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_entry;

    typedef struct packed {
        logic [9:0]        id;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [26:0]       mm;
        logic signed [31:0] spd;
        logic signed [15:0] brg;
        logic              dropped;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [30:0]       ax;
        logic [30:0]       ay;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic              sh;
    } t_rng_in;

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SCMP, S_APP, S_Q1, S_Q2, S_Q3, S_YAW,
        S_PRD, S_PDIF, S_PSC, S_PWAIT
    } t_bstate;

    typedef enum logic [1:0] {
        C_IDLE, C_NORM, C_ROT
    } t_cstate;

    typedef enum logic [2:0] {
        R_IDLE, R_MUL, R_SQRT, R_MM, R_DIV, R_FIN
    } t_rstate;

endpackage

`default_nettype wire

@@ src/mtrb_queue.sv @@
// ----------------------------------------------------------------------------
// Marker table front queue
// Accepts input items, classifies them and holds up to two for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrb_queue
    import mtrb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_stall,
    input  wire logic              i_cmd,
    input  wire logic [9:0]        i_marker_id,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic              i_no_depth,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    output      logic              o_q_valid,
    input  wire logic              i_q_pop,
    output      t_item             o_q_item
);

    t_item      r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_fill;
    logic       push, pop;
    t_item      item;

    // classify: pose or observation, and whether an observation keeps the entry
    always_comb begin
        item.is_pose  = i_cmd;
        item.hold_pos = (i_pos_x == 32'sd0) && (i_pos_y == 32'sd0) && i_no_depth;
        item.id       = i_marker_id;
        item.px       = i_pos_x;
        item.py       = i_pos_y;
        item.qx       = i_quat_x;
        item.qy       = i_quat_y;
        item.qz       = i_quat_z;
        item.qw       = i_quat_w;
        item.vx       = i_vel_x;
        item.vy       = i_vel_y;
    end

    assign o_stall   = (r_fill == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_fill != 2'd0);
    assign pop       = o_q_valid && i_q_pop;
    assign o_q_item  = r_slot[r_rd];

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

    // store the transfer
    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wr] <= item;
    end

endmodule

`default_nettype wire

@@ src/mtrb_cordic.sv @@
// ----------------------------------------------------------------------------
// Marker table arctangent unit
// Iterative atan2 in 2^-16 rad: quadrant fold, normalise, 16 vectoring steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrb_cordic
    import mtrb_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [CIN_W-1:0] i_y,
    input  wire logic signed [CIN_W-1:0] i_x,
    output      logic                    o_busy,
    output      logic signed [ANG_W-1:0] o_z
);

    t_cstate                 r_st, n_st;
    logic signed [CW-1:0]    r_x, n_x, r_y, n_y;
    logic signed [ANG_W-1:0] r_z, n_z;
    logic [3:0]              r_i, n_i;

    always_comb begin
        logic signed [CW-1:0] xin, yin, xs, ys, xa, ya;
        xin  = CW'(i_x);
        yin  = CW'(i_y);
        xs   = r_x >>> r_i;
        ys   = r_y >>> r_i;
        xa   = r_x[CW-1] ? -r_x : r_x;
        ya   = r_y[CW-1] ? -r_y : r_y;
        n_st = r_st;
        n_x  = r_x;
        n_y  = r_y;
        n_z  = r_z;
        n_i  = r_i;
        case (r_st)
            C_IDLE: begin
                if (i_start) begin
                    n_i = 4'd0;
                    if (xin == '0 && yin == '0) begin
                        n_z = '0;
                    end else if (xin[CW-1]) begin
                        n_z  = yin[CW-1] ? -ANG_PI : ANG_PI;
                        n_x  = -xin;
                        n_y  = -yin;
                        n_st = C_NORM;
                    end else begin
                        n_z  = '0;
                        n_x  = xin;
                        n_y  = yin;
                        n_st = C_NORM;
                    end
                end
            end
            C_NORM: begin
                // double both until one reaches 2^30
                if (xa < (CW'(1) <<< 30) && ya < (CW'(1) <<< 30)) begin
                    n_x = r_x <<< 1;
                    n_y = r_y <<< 1;
                end else begin
                    n_st = C_ROT;
                end
            end
            C_ROT: begin
                if (!r_y[CW-1]) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + atan_step(r_i);
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - atan_step(r_i);
                end
                n_i = r_i + 4'd1;
                if (r_i == 4'(CORDIC_STEPS - 1)) n_st = C_IDLE;
            end
            default: n_st = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_IDLE;
            r_i  <= 4'd0;
        end else begin
            r_st <= n_st;
            r_i  <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_busy = (r_st != C_IDLE);
    assign o_z    = r_z;

endmodule

`default_nettype wire

@@ src/mtrb_range.sv @@
// ----------------------------------------------------------------------------
// Marker table range unit
// Squares and dot product on one multiplier, bitwise root, restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrb_range
    import mtrb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_rng_in           i_op,
    output      logic              o_busy,
    output      logic [26:0]       o_mm,
    output      logic signed [31:0] o_spd
);

    t_rstate            r_st, n_st;
    t_rng_in            r_op, n_op;
    logic [1:0]         r_ph, n_ph;
    logic [5:0]         r_cnt, n_cnt;
    logic [63:0]        r_sq, n_sq, r_res, n_res, r_bit, n_bit, r_num, n_num;
    logic signed [63:0] r_dot, n_dot;
    logic [31:0]        r_rem, n_rem;
    logic               r_neg, n_neg;
    logic [26:0]        r_mm, n_mm;
    logic signed [31:0] r_spd, n_spd;

    always_comb begin
        logic signed [31:0] op_a, op_b;
        logic signed [63:0] prod;
        logic [63:0]        t;
        logic [33:0]        full;
        logic [43:0]        mmp;
        logic [32:0]        rem2;
        n_st  = r_st;
        n_op  = r_op;
        n_ph  = r_ph;
        n_cnt = r_cnt;
        n_sq  = r_sq;
        n_res = r_res;
        n_bit = r_bit;
        n_num = r_num;
        n_dot = r_dot;
        n_rem = r_rem;
        n_neg = r_neg;
        n_mm  = r_mm;
        n_spd = r_spd;
        // select operands of the shared multiplier
        case (r_ph)
            2'd0:    begin op_a = {1'b0, r_op.ax}; op_b = {1'b0, r_op.ax}; end
            2'd1:    begin op_a = {1'b0, r_op.ay}; op_b = {1'b0, r_op.ay}; end
            2'd2:    begin op_a = r_op.sx; op_b = r_op.vx; end
            default: begin op_a = r_op.sy; op_b = r_op.vy; end
        endcase
        prod = op_a * op_b;
        t    = r_res + r_bit;
        full = r_op.sh ? {r_res[31:0], 2'b00} : {2'b00, r_res[31:0]};
        mmp  = 44'(full) * 44'(MM_SCALE);
        rem2 = {r_rem, r_num[63]};
        case (r_st)
            R_IDLE: begin
                if (i_start) begin
                    n_op = i_op;
                    n_ph = 2'd0;
                    n_st = R_MUL;
                end
            end
            R_MUL: begin
                case (r_ph)
                    2'd0:    n_sq  = 64'(prod);
                    2'd1:    n_sq  = r_sq + 64'(prod);
                    2'd2:    n_dot = prod;
                    default: n_dot = r_dot + prod;
                endcase
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    n_res = '0;
                    n_bit = 64'd1 << 62;
                    n_cnt = '0;
                    n_st  = R_SQRT;
                end
            end
            R_SQRT: begin
                // one result bit a step
                if (r_sq >= t) begin
                    n_sq  = r_sq - t;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) n_st = R_MM;
            end
            R_MM: begin
                n_mm  = mmp[43:43] != 1'b0 || mmp[42:16] == '1 || mmp[43:16] > 28'h7FFFFFF
                        ? 27'h7FFFFFF : mmp[42:16];
                n_neg = r_dot[63];
                n_num = r_dot[63] ? 64'(-r_dot) : 64'(r_dot);
                n_rem = '0;
                n_cnt = '0;
                if (r_res[31:0] == 32'd0) begin
                    n_spd = '0;
                    n_st  = R_IDLE;
                end else begin
                    n_st = R_DIV;
                end
            end
            R_DIV: begin
                // restoring divide, quotient shifts into the numerator
                if (rem2 >= {1'b0, r_res[31:0]}) begin
                    n_rem = 32'(rem2 - {1'b0, r_res[31:0]});
                    n_num = {r_num[62:0], 1'b1};
                end else begin
                    n_rem = rem2[31:0];
                    n_num = {r_num[62:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) n_st = R_FIN;
            end
            R_FIN: begin
                if (r_neg) begin
                    n_spd = (r_num > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(r_num[31:0]);
                end else begin
                    n_spd = (r_num > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_num[31:0]);
                end
                n_st = R_IDLE;
            end
            default: n_st = R_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= R_IDLE;
            r_ph  <= 2'd0;
            r_cnt <= 6'd0;
        end else begin
            r_st  <= n_st;
            r_ph  <= n_ph;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_sq  <= n_sq;
        r_res <= n_res;
        r_bit <= n_bit;
        r_num <= n_num;
        r_dot <= n_dot;
        r_rem <= n_rem;
        r_neg <= n_neg;
        r_mm  <= n_mm;
        r_spd <= n_spd;
    end

    assign o_busy = (r_st != R_IDLE);
    assign o_mm   = r_mm;
    assign o_spd  = r_spd;

endmodule

`default_nettype wire

@@ src/mtrb_back.sv @@
// ----------------------------------------------------------------------------
// Marker table back end
// Table memory, update and append, and the per-entry report sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "marker_table_range_bearing_defines.svh"

module mtrb_back
    import mtrb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    output      logic    o_q_pop,
    input  wire t_item   i_q_item,
    output      logic    o_valid,
    input  wire logic    i_stall,
    output      t_result o_res
);

    t_bstate                 r_st, n_st;
    t_item                   r_item, n_item;
    logic [IDX_W-1:0]        r_k, n_k;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_drop, n_drop;
    t_entry                  r_mem [CAPACITY];
    t_entry                  r_rd;
    t_entry                  r_ent, n_ent;
    logic signed [31:0]      r_pxx, r_pyy, r_pzz, r_pww, r_pxz, r_pwy, r_pxy, r_pwz;
    logic signed [31:0]      n_pxx, n_pyy, n_pzz, n_pww, n_pxz, n_pwy, n_pxy, n_pwz;
    logic signed [33:0]      r_qd, r_qg, r_qy, r_qx, n_qd, n_qg, n_qy, n_qx;
    logic signed [ANG_W-1:0] r_yaw, n_yaw;
    logic signed [32:0]      r_dx, r_dy, n_dx, n_dy;
    t_result                 r_out, n_out;
    logic                    r_out_valid, out_load;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    t_entry                  wdata;
    logic                    last_k;
    logic                    c_start, c_busy;
    logic signed [CIN_W-1:0] c_y, c_x;
    logic signed [ANG_W-1:0] c_z;
    logic                    rg_start, rg_busy;
    t_rng_in                 rg_op;
    logic [26:0]             rg_mm;
    logic signed [31:0]      rg_spd;

    mtrb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_y     (c_y),
        .i_x     (c_x),
        .o_busy  (c_busy),
        .o_z     (c_z)
    );

    mtrb_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rg_start),
        .i_op    (rg_op),
        .o_busy  (rg_busy),
        .o_mm    (rg_mm),
        .o_spd   (rg_spd)
    );

    assign last_k = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);

    always_comb begin
        logic [32:0]             ax, ay, axs, ays;
        logic                    sh;
        logic [33:0]             g_abs;
        logic signed [ANG_W-1:0] brg;
        logic signed [ANG_W-1:0] rnd;
        n_st     = r_st;
        n_item   = r_item;
        n_k      = r_k;
        n_count  = r_count;
        n_drop   = r_drop;
        n_ent    = r_ent;
        n_pxx    = r_pxx;  n_pyy = r_pyy;  n_pzz = r_pzz;  n_pww = r_pww;
        n_pxz    = r_pxz;  n_pwy = r_pwy;  n_pxy = r_pxy;  n_pwz = r_pwz;
        n_qd     = r_qd;   n_qg  = r_qg;   n_qy  = r_qy;   n_qx  = r_qx;
        n_yaw    = r_yaw;
        n_dx     = r_dx;
        n_dy     = r_dy;
        o_q_pop  = 1'b0;
        we       = 1'b0;
        waddr    = r_k;
        wdata    = '{id: r_item.id, x: r_item.px, y: r_item.py};
        c_start  = 1'b0;
        c_y      = CIN_W'(r_dy);
        c_x      = CIN_W'(r_dx);
        rg_start = 1'b0;
        out_load = 1'b0;

        // scale the offsets when either reaches 2^31
        ax  = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
        ay  = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
        sh  = ax[32] | ax[31] | ay[32] | ay[31];
        axs = sh ? (ax >> 2) : ax;
        ays = sh ? (ay >> 2) : ay;
        rg_op.ax = axs[30:0];
        rg_op.ay = ays[30:0];
        rg_op.sx = r_dx[32] ? -$signed({1'b0, axs[30:0]}) : $signed({1'b0, axs[30:0]});
        rg_op.sy = r_dy[32] ? -$signed({1'b0, ays[30:0]}) : $signed({1'b0, ays[30:0]});
        rg_op.vx = r_item.vx;
        rg_op.vy = r_item.vy;
        rg_op.sh = sh;

        // relative bearing, wrapped and rounded to Q3.13
        brg = c_z - r_yaw;
        if (brg > ANG_PI)       brg = brg - ANG_TWO_PI;
        else if (brg < -ANG_PI) brg = brg + ANG_TWO_PI;
        rnd = (brg + ANG_W'(4)) >>> 3;

        n_out.id      = r_ent.id;
        n_out.x       = r_ent.x;
        n_out.y       = r_ent.y;
        n_out.mm      = rg_mm;
        n_out.spd     = rg_spd;
        n_out.brg     = rnd[15:0];
        n_out.dropped = r_drop;
        n_out.last    = last_k;

        g_abs = r_qg[33] ? 34'(-r_qg) : 34'(r_qg);

        case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_k     = '0;
                    if (i_q_item.is_pose)        n_st = S_Q1;
                    else if (r_count == '0)      n_st = S_APP;
                    else                         n_st = S_SRD;
                end
            end
            S_SRD: n_st = S_SCMP;
            S_SCMP: begin
                if (r_rd.id == r_item.id) begin
                    we   = !r_item.hold_pos;
                    n_st = S_IDLE;
                end else if (last_k) begin
                    n_st = S_APP;
                end else begin
                    n_k  = r_k + IDX_W'(1);
                    n_st = S_SRD;
                end
            end
            S_APP: begin
                if (r_count < CNT_W'(CAPACITY)) begin
                    we      = 1'b1;
                    waddr   = r_count[IDX_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_drop = 1'b1;
                end
                n_st = S_IDLE;
            end
            S_Q1: begin
                n_pxx = r_item.qx * r_item.qx;
                n_pyy = r_item.qy * r_item.qy;
                n_pzz = r_item.qz * r_item.qz;
                n_pww = r_item.qw * r_item.qw;
                n_pxz = r_item.qx * r_item.qz;
                n_pwy = r_item.qw * r_item.qy;
                n_pxy = r_item.qx * r_item.qy;
                n_pwz = r_item.qw * r_item.qz;
                n_st  = S_Q2;
            end
            S_Q2: begin
                n_qd = 34'(r_pxx) + 34'(r_pyy) + 34'(r_pzz) + 34'(r_pww);
                n_qg = (34'(r_pxz) - 34'(r_pwy)) <<< 1;
                n_qy = (34'(r_pxy) + 34'(r_pwz)) <<< 1;
                n_qx = 34'(r_pww) + 34'(r_pxx) - 34'(r_pyy) - 34'(r_pzz);
                n_st = S_Q3;
            end
            S_Q3: begin
                if (g_abs < 34'(r_qd)) begin
                    c_start = 1'b1;
                    c_y     = CIN_W'(r_qy);
                    c_x     = CIN_W'(r_qx);
                    n_st    = S_YAW;
                end else begin
                    n_yaw = '0;
                    n_st  = (r_count == '0) ? S_IDLE : S_PRD;
                end
            end
            S_YAW: begin
                if (!c_busy) begin
                    n_yaw = c_z;
                    n_st  = (r_count == '0) ? S_IDLE : S_PRD;
                end
            end
            S_PRD: n_st = S_PDIF;
            S_PDIF: begin
                n_ent = r_rd;
                n_dx  = 33'(r_rd.x) - 33'(r_item.px);
                n_dy  = 33'(r_rd.y) - 33'(r_item.py);
                n_st  = S_PSC;
            end
            S_PSC: begin
                c_start  = 1'b1;
                rg_start = 1'b1;
                n_st     = S_PWAIT;
            end
            S_PWAIT: begin
                if (!c_busy && !rg_busy && (!r_out_valid || !i_stall)) begin
                    out_load = 1'b1;
                    if (last_k) begin
                        n_st = S_IDLE;
                    end else begin
                        n_k  = r_k + IDX_W'(1);
                        n_st = S_PRD;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_k     <= '0;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_k     <= n_k;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_ent  <= n_ent;
        r_pxx  <= n_pxx;  r_pyy <= n_pyy;  r_pzz <= n_pzz;  r_pww <= n_pww;
        r_pxz  <= n_pxz;  r_pwy <= n_pwy;  r_pxy <= n_pxy;  r_pwz <= n_pwz;
        r_qd   <= n_qd;   r_qg  <= n_qg;   r_qy  <= n_qy;   r_qx  <= n_qx;
        r_yaw  <= n_yaw;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
    end

    // table memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd <= r_mem[r_k];
    end

    // output register: hold while stalled, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    `MTRB_ASSERT_IMPL(a_count_cap, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count over capacity")
    `MTRB_ASSERT_NEXT(a_drop_sticky, r_drop, r_drop, "drop flag cleared")
    `MTRB_ASSERT_IMPL(a_cordic_free, c_start, !c_busy, "arctangent unit started while busy")
    `MTRB_ASSERT_IMPL(a_range_free, rg_start, !rg_busy, "range unit started while busy")

endmodule

`default_nettype wire

@@ src/marker_table_range_bearing.sv @@
// ----------------------------------------------------------------------------
// Marker table with range and bearing report
// Observations keep a table of markers; a robot pose reports every entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one item per transfer. An item with
//   i_cmd low is a marker observation: it updates or appends a table entry and
//   gives no result. An item with i_cmd high is a robot pose: it gives one
//   result per stored entry, in insertion order, o_last high on the final one.
//   Output channel o_valid / i_stall; a stalled result holds, and the sequencer
//   waits for the output register to free before loading the next one.
//   A two-item queue sits in front, so the sender is stalled only when full.
//   Observation: searches the stored entries in order, then updates or appends.
//   Pose: sets up the yaw, using the arctangent unit, then per entry runs the
//   range unit (4 multiply steps, 32 root steps, 64 divide steps) with the
//   arctangent running beside it.
//   Reset empties the table and clears the drop flag; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_table_range_bearing
    import mtrb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_stall,
    input  wire logic              i_cmd,
    input  wire logic [9:0]        i_marker_id,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic              i_no_depth,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    output      logic              o_valid,
    input  wire logic              i_stall,
    output      logic [9:0]        o_entry_id,
    output      logic signed [31:0] o_entry_x,
    output      logic signed [31:0] o_entry_y,
    output      logic [26:0]       o_range_mm,
    output      logic signed [31:0] o_closing_speed,
    output      logic signed [15:0] o_bearing,
    output      logic              o_dropped,
    output      logic              o_last
);

    logic    q_valid, q_pop;
    t_item   q_item;
    t_result res;

    mtrb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_marker_id (i_marker_id),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_no_depth  (i_no_depth),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_quat_w    (i_quat_w),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_item    (q_item)
    );

    mtrb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_item  (q_item),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (res)
    );

    // unpack the result register onto the ports
    assign o_entry_id      = res.id;
    assign o_entry_x       = res.x;
    assign o_entry_y       = res.y;
    assign o_range_mm      = res.mm;
    assign o_closing_speed = res.spd;
    assign o_bearing       = res.brg;
    assign o_dropped       = res.dropped;
    assign o_last          = res.last;

endmodule

`default_nettype wire

@@ sim/mtrb_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Marker table checker
// Watches both channels, keeps its own copy of the marker table, computes the
// report expected for each pose transfer and compares every result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrb_checker
    import mtrb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_in_stall,
    input  wire logic              i_cmd,
    input  wire logic [9:0]        i_marker_id,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic              i_no_depth,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [9:0]        i_entry_id,
    input  wire logic signed [31:0] i_entry_x,
    input  wire logic signed [31:0] i_entry_y,
    input  wire logic [26:0]       i_range_mm,
    input  wire logic signed [31:0] i_closing_speed,
    input  wire logic signed [15:0] i_bearing,
    input  wire logic              i_dropped,
    input  wire logic              i_last,
    output      int                o_errors,
    output      int                o_pending,
    output      int                o_reports,
    output      int                o_results
);

    localparam longint HALF_TURN = 205887;
    localparam longint FULL_TURN = 411774;

    t_result     report_q[$];
    logic [9:0]  tbl_id[CAPACITY];
    longint      tbl_x[CAPACITY];
    longint      tbl_y[CAPACITY];
    int          tbl_n;
    logic        lost;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint int_root(longint v);
        longint res, bit_w;
        res = 0;
        bit_w = 64'sd1 <<< 62;
        while (bit_w > v) bit_w = bit_w >>> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >>> 1) + bit_w;
            end else begin
                res = res >>> 1;
            end
            bit_w = bit_w >>> 2;
        end
        return res;
    endfunction

    // 16-step rotation arctangent, 2^-16 rad units
    function automatic longint arctan2(longint y, longint x);
        longint z, xs, ys;
        longint steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        while (absl(x) < (64'sd1 <<< 30) && absl(y) < (64'sd1 <<< 30)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 16; i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + steps[i];
            end else begin
                x = x - ys; y = y + xs; z = z - steps[i];
            end
        end
        return z;
    endfunction

    // update or append one observed marker
    task automatic record_marker();
        bit hit;
        hit = 0;
        for (int k = 0; k < tbl_n; k++) begin
            if (!hit && tbl_id[k] == i_marker_id) begin
                hit = 1;
                if (!(i_pos_x == 0 && i_pos_y == 0 && i_no_depth)) begin
                    tbl_x[k] = i_pos_x;
                    tbl_y[k] = i_pos_y;
                end
            end
        end
        if (!hit) begin
            if (tbl_n < CAPACITY) begin
                tbl_id[tbl_n] = i_marker_id;
                tbl_x[tbl_n] = i_pos_x;
                tbl_y[tbl_n] = i_pos_y;
                tbl_n++;
            end else begin
                lost = 1;
            end
        end
    endtask

    // queue one result per stored marker for this pose
    task automatic predict_report();
        longint qx, qy, qz, qw, vx, vy, nrm, gim, yaw;
        longint dx, dy, ax, ay, sx, sy, r, full, mm, dot, spd, brg;
        int s;
        t_result e;
        qx = i_quat_x; qy = i_quat_y; qz = i_quat_z; qw = i_quat_w;
        vx = i_vel_x; vy = i_vel_y;
        nrm = qx*qx + qy*qy + qz*qz + qw*qw;
        gim = 2 * (qx*qz - qw*qy);
        yaw = 0;
        if (absl(gim) < nrm)
            yaw = arctan2(2 * (qx*qy + qw*qz), qw*qw + qx*qx - qy*qy - qz*qz);
        for (int k = 0; k < tbl_n; k++) begin
            dx = tbl_x[k] - longint'(i_pos_x);
            dy = tbl_y[k] - longint'(i_pos_y);
            ax = absl(dx); ay = absl(dy);
            s = (ax >= (64'sd1 <<< 31) || ay >= (64'sd1 <<< 31)) ? 2 : 0;
            ax = ax >>> s; ay = ay >>> s;
            sx = dx < 0 ? -ax : ax;
            sy = dy < 0 ? -ay : ay;
            r = int_root(ax*ax + ay*ay);
            full = r <<< s;
            mm = (full * 1000) >>> 16;
            if (mm > 64'h7FFFFFF) mm = 64'h7FFFFFF;
            dot = sx*vx + sy*vy;
            spd = (r == 0) ? 0 : dot / r;
            if (spd > 64'sd2147483647) spd = 64'sd2147483647;
            if (spd < -64'sd2147483648) spd = -64'sd2147483648;
            brg = arctan2(dy, dx) - yaw;
            if (brg > HALF_TURN) brg = brg - FULL_TURN;
            else if (brg < -HALF_TURN) brg = brg + FULL_TURN;
            brg = fshr(brg + 4, 3);
            e.id = tbl_id[k];
            e.x = tbl_x[k][31:0];
            e.y = tbl_y[k][31:0];
            e.mm = mm[26:0];
            e.spd = spd[31:0];
            e.brg = brg[15:0];
            e.dropped = lost;
            e.last = (k + 1 == tbl_n);
            report_q.insert(report_q.size(), e);
        end
    endtask

    task automatic compare_result();
        t_result e;
        if (report_q.size() == 0) begin
            $error("unexpected result id=%0d", i_entry_id);
            o_errors++;
        end else begin
            e = report_q.pop_front();
            if (i_entry_id !== e.id) begin
                $error("entry_id exp %0d got %0d", e.id, i_entry_id); o_errors++;
            end
            if (i_entry_x !== e.x) begin
                $error("entry_x exp %0d got %0d", e.x, i_entry_x); o_errors++;
            end
            if (i_entry_y !== e.y) begin
                $error("entry_y exp %0d got %0d", e.y, i_entry_y); o_errors++;
            end
            if (i_range_mm !== e.mm) begin
                $error("range_mm exp %0d got %0d", e.mm, i_range_mm); o_errors++;
            end
            if (i_closing_speed !== e.spd) begin
                $error("closing_speed exp %0d got %0d", e.spd, i_closing_speed);
                o_errors++;
            end
            if (i_bearing !== e.brg) begin
                $error("bearing exp %0d got %0d", e.brg, i_bearing); o_errors++;
            end
            if (i_dropped !== e.dropped) begin
                $error("dropped exp %0d got %0d", e.dropped, i_dropped); o_errors++;
            end
            if (i_last !== e.last) begin
                $error("last exp %0d got %0d", e.last, i_last); o_errors++;
            end
        end
    endtask

    initial begin
        o_errors = 0;
        o_reports = 0;
        o_results = 0;
        tbl_n = 0;
        lost = 0;
    end

    // results leave first, then the new transfer is modelled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                compare_result();
                o_results++;
            end
            if (i_valid && !i_in_stall) begin
                if (i_cmd) begin
                    predict_report();
                    o_reports++;
                end else begin
                    record_marker();
                end
            end
        end
        o_pending = report_q.size();
    end

endmodule

`default_nettype wire

@@ sim/tb_marker_table_range_bearing.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Marker table testbench
// Drives observations and poses with random gaps and stalls; the checker
// beside the block predicts each report and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_marker_table_range_bearing;
    import mtrb_pkg::*;

    localparam bit CMD_OBS  = 1'b0;
    localparam bit CMD_POSE = 1'b1;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_valid = 0;
    logic              o_stall;
    logic              i_cmd = 0;
    logic [9:0]        i_marker_id = 0;
    logic signed [31:0] i_pos_x = 0, i_pos_y = 0;
    logic              i_no_depth = 0;
    logic signed [15:0] i_quat_x = 0, i_quat_y = 0, i_quat_z = 0, i_quat_w = 0;
    logic signed [31:0] i_vel_x = 0, i_vel_y = 0;
    logic              o_valid;
    logic              i_stall = 0;
    logic [9:0]        o_entry_id;
    logic signed [31:0] o_entry_x, o_entry_y, o_closing_speed;
    logic [26:0]       o_range_mm;
    logic signed [15:0] o_bearing;
    logic              o_dropped, o_last;
    int                errors, pending, reports, results;
    int                send_idle = 8, recv_idle = 45;
    int                hold_off = 0;

    always #5 i_clk = ~i_clk;

    marker_table_range_bearing dut (.*);

    mtrb_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_cmd, .i_marker_id,
        .i_pos_x, .i_pos_y, .i_no_depth, .i_quat_x, .i_quat_y, .i_quat_z,
        .i_quat_w, .i_vel_x, .i_vel_y, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_entry_id(o_entry_id), .i_entry_x(o_entry_x), .i_entry_y(o_entry_y),
        .i_range_mm(o_range_mm), .i_closing_speed(o_closing_speed),
        .i_bearing(o_bearing), .i_dropped(o_dropped), .i_last(o_last),
        .o_errors(errors), .o_pending(pending), .o_reports(reports),
        .o_results(results)
    );

    // receiver stall: long hold-off when asked, else random
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_stall <= 1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    function automatic logic signed [31:0] rnd_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000000)) - 1000000;
            2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 40000000)) - 20000000;
        endcase
    endfunction

    function automatic logic signed [15:0] rnd_q();
        return $urandom_range(3) == 0 ? 16'($urandom)
                                      : 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // idle with a scrambled payload, then offer one item until it transfers
    task automatic send(input bit cmd, input logic [9:0] id, input logic signed [31:0] x,
                        input logic signed [31:0] y, input bit nd,
                        input logic signed [15:0] qx, input logic signed [15:0] qy,
                        input logic signed [15:0] qz, input logic signed [15:0] qw,
                        input logic signed [31:0] vx, input logic signed [31:0] vy);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            i_cmd <= 1'($urandom); i_marker_id <= 10'($urandom); i_pos_x <= $urandom;
            @(negedge i_clk);
        end
        i_valid <= 1; i_cmd <= cmd; i_marker_id <= id; i_pos_x <= x; i_pos_y <= y;
        i_no_depth <= nd; i_quat_x <= qx; i_quat_y <= qy; i_quat_z <= qz;
        i_quat_w <= qw; i_vel_x <= vx; i_vel_y <= vy;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic observe(input logic [9:0] id, input logic signed [31:0] x,
                           input logic signed [31:0] y, input bit nd);
        send(CMD_OBS, id, x, y, nd, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), $urandom, $urandom);
    endtask

    task automatic pose(input logic signed [31:0] x, input logic signed [31:0] y,
                        input logic signed [15:0] qx, input logic signed [15:0] qy,
                        input logic signed [15:0] qz, input logic signed [15:0] qw,
                        input logic signed [31:0] vx, input logic signed [31:0] vy);
        send(CMD_POSE, 10'($urandom), x, y, 1'($urandom), qx, qy, qz, qw, vx, vy);
    endtask

    task automatic random_pose();
        pose(rnd_pos(), rnd_pos(), rnd_q(), rnd_q(), rnd_q(), rnd_q(),
             $urandom_range(1) ? $urandom : $signed($urandom_range(0, 400000)) - 200000,
             $urandom_range(1) ? $urandom : $signed($urandom_range(0, 400000)) - 200000);
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 20) begin
                random_pose();
            end else begin
                observe($urandom_range(1) ? 10'($urandom_range(0, 40)) : 10'($urandom),
                        $urandom_range(9) == 0 ? 32'sd0 : rnd_pos(),
                        $urandom_range(9) == 0 ? 32'sd0 : rnd_pos(), 1'($urandom));
            end
        end
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // empty table, then extremes and the no-depth hold
        pose(0, 0, 0, 0, 0, 0, 0, 0);
        observe(10'd0, 32'sh7FFFFFFF, 32'sh80000000, 0);
        observe(10'd1023, 32'sh80000000, 32'sh7FFFFFFF, 1);
        observe(10'd5, 32'sd65536, 32'sd0, 0);
        observe(10'd5, 32'sd0, 32'sd0, 1);
        observe(10'd6, 32'sd0, 32'sd0, 1);
        observe(10'd6, 32'sd0, 32'sd0, 0);
        pose(32'sd65536, 0, 0, 0, 0, 16'sd16384, 32'sh7FFFFFFF, 32'sh80000000);
        pose(32'sh80000000, 32'sh7FFFFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
             32'sh80000000, 32'sh7FFFFFFF);
        pose(0, 0, 16'sd16384, 0, 16'sd16384, 0, 100000, -100000);
        pose(0, 0, 0, 0, 16'sd16384, 0, 0, 0);
        drain();

        random_phase(150);
        drain();
        send_idle = 45; recv_idle = 8;
        random_phase(150);
        // fill the table then overflow it
        for (int i = 0; i < CAPACITY + 3; i++)
            observe(10'(100 + i), rnd_pos(), rnd_pos(), 1'($urandom));
        drain();
        send_idle = 0; recv_idle = 0;
        // long receiver hold-off with poses queueing behind it
        hold_off = 3000;
        repeat (6) random_pose();
        random_phase(110);
        drain();

        $display("Covered %0d pose reports and %0d result transfers,", reports, results);
        $display("table fill, overflow drop and held observations included.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #60ms;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
